// ----- hw/rtl/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
`default_nettype none

package krt_pkg;

  localparam int KEY_W = 16;
  localparam int AGE_W = 8;
  localparam int NAME_W_MAX = 64;
  localparam int SLOT_W = 6;
  localparam int DEF_SLOTS = 64;
  localparam int DEF_NAME_BYTES = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  localparam logic [KEY_W-1:0] KEY_FIRST = 16'd1;
  localparam logic [KEY_W-1:0] KEY_LAST  = 16'hFFFF;

endpackage

`default_nettype wire

// ----- hw/rtl/krt_ram.sv -----
// Simple dual-port record memory with one write port and a registered read port.
`default_nettype none

module krt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 88
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_record_table_swap_remove.sv -----
// Top level of the keyed record table with swap-remove on delete.
//
// A command is transferred at a rising edge where start is high and busy is
// low. Every command gives exactly one result, shown on status, slot and
// assigned_key for one cycle while done is high; the receiver cannot stall.
// Insert and clear stay in the idle state: done rises in the cycle after the
// transfer and busy stays low, so commands of these kinds can follow each
// other in every cycle. Insert writes the record at slot live_count and
// hands out the next key, wrapping from 65535 to 1, unless the table is full.
// Find and delete scan the live slots through the registered read port of the
// record memory, one slot per cycle. A find or delete on an empty table gives
// done in the cycle after the transfer without a scan. A delete that hits
// then passes through ST_MOVE_RD and ST_MOVE_WR, reading the last live
// record and writing it into the freed slot. So the time per find or delete
// grows with live_count. Reset empties the table and sets the next key to 1;
// the memory contents are not cleared, since only live slots are ever read.
`default_nettype none

module keyed_record_table_swap_remove
  import krt_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS,
  parameter int NAME_BYTES = DEF_NAME_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            operation,
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [AGE_W-1:0]      age,
  input  wire logic [NAME_W_MAX-1:0] name_payload,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [SLOT_W-1:0]          slot,
  output logic [KEY_W-1:0]           assigned_key
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = 8 * NAME_BYTES;
  localparam int REC_W = KEY_W + AGE_W + NW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR
  } state_t;

  state_t state;
  logic [CW-1:0] live_count;
  logic [KEY_W-1:0] next_key;
  logic [KEY_W-1:0] key_r;
  logic is_delete;
  logic [CW-1:0] issue_idx;
  logic cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] found_idx;

  logic full;
  logic [AW-1:0] last_idx;
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic ram_re;
  logic [AW-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic take_insert;

  assign busy = (state != ST_IDLE);
  assign full = (live_count == CW'(SLOTS));
  assign last_idx = AW'(live_count - 1'b1);
  assign rd_key = ram_rdata[REC_W-1 -: KEY_W];
  assign take_insert = (state == ST_IDLE) && start && (operation == OP_INSERT) && !full;

  always_comb begin
    ram_we = take_insert || (state == ST_MOVE_WR);
    ram_waddr = (state == ST_MOVE_WR) ? found_idx : live_count[AW-1:0];
    ram_wdata = (state == ST_MOVE_WR) ? ram_rdata : {next_key, age, name_payload[NW-1:0]};
    ram_re = ((state == ST_SCAN) && (issue_idx < live_count)) || (state == ST_MOVE_RD);
    ram_raddr = (state == ST_MOVE_RD) ? last_idx : issue_idx[AW-1:0];
  end

  krt_ram #(
    .DEPTH(SLOTS),
    .WIDTH(REC_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      live_count <= '0;
      next_key <= KEY_FIRST;
      done <= 1'b0;
      status <= STAT_OK;
      slot <= '0;
      assigned_key <= '0;
      cmp_valid <= 1'b0;
      issue_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            status <= STAT_OK;
            slot <= '0;
            assigned_key <= '0;
            key_r <= key;
            is_delete <= (operation == OP_DELETE);
            unique case (operation)
              OP_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= STAT_FULL;
                end else begin
                  slot <= SLOT_W'(live_count[AW-1:0]);
                  assigned_key <= next_key;
                  live_count <= live_count + 1'b1;
                  next_key <= (next_key == KEY_LAST) ? KEY_FIRST : next_key + 1'b1;
                end
              end
              OP_DELETE, OP_FIND: begin
                if (live_count == '0) begin
                  done <= 1'b1;
                  status <= STAT_NOT_FOUND;
                end else begin
                  state <= ST_SCAN;
                  issue_idx <= '0;
                  cmp_valid <= 1'b0;
                end
              end
              OP_CLEAR: begin
                done <= 1'b1;
                live_count <= '0;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            issue_idx <= issue_idx + 1'b1;
          end
          cmp_valid <= ram_re;
          cmp_idx <= issue_idx[AW-1:0];
          if (cmp_valid && (rd_key == key_r)) begin
            found_idx <= cmp_idx;
            cmp_valid <= 1'b0;
            if (is_delete) begin
              state <= ST_MOVE_RD;
            end else begin
              state <= ST_IDLE;
              done <= 1'b1;
              slot <= SLOT_W'(cmp_idx);
            end
          end else if (cmp_valid && (cmp_idx == last_idx)) begin
            cmp_valid <= 1'b0;
            state <= ST_IDLE;
            done <= 1'b1;
            status <= STAT_NOT_FOUND;
          end
        end
        ST_MOVE_RD: begin
          state <= ST_MOVE_WR;
        end
        ST_MOVE_WR: begin
          state <= ST_IDLE;
          live_count <= live_count - 1'b1;
          done <= 1'b1;
          slot <= SLOT_W'(found_idx);
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_keyed_record_table_swap_remove.sv -----
// Self-checking testbench for the keyed record table with swap-remove.
`timescale 1ns / 100ps

module tb_keyed_record_table_swap_remove;
  import krt_pkg::*;

  localparam int SLOTS = DEF_SLOTS;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [KEY_W-1:0]      akey;
  } response_t;

  typedef struct packed {
    op_t                   op;
    logic [KEY_W-1:0]      key;
    logic [AGE_W-1:0]      age;
    logic [NAME_W_MAX-1:0] name;
    logic                  fixed;
    response_t             resp;
  } stim_row_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  localparam stim_row_t DIRECTED_ROWS [20] = '{
    '{OP_FIND,   16'd1,      8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_DELETE, 16'd0,      8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_INSERT, 16'hFFFF,   8'h00, 64'd0,                 1'b1, '{STAT_OK, 6'd0, 16'd1}},
    '{OP_INSERT, 16'h0000,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{STAT_OK, 6'd1, 16'd2}},
    '{OP_INSERT, 16'h5A5A,   8'h5A, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, '{STAT_OK, 6'd2, 16'd3}},
    '{OP_FIND,   16'd1,      8'h00, 64'd0,                 1'b1, '{STAT_OK, 6'd0, 16'd0}},
    '{OP_FIND,   16'd3,      8'hFF, 64'd0,                 1'b1, '{STAT_OK, 6'd2, 16'd0}},
    '{OP_FIND,   16'hFFFF,   8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_FIND,   16'd0,      8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_DELETE, 16'd1,      8'h00, 64'd0,                 1'b1, '{STAT_OK, 6'd0, 16'd0}},
    '{OP_FIND,   16'd3,      8'h00, 64'd0,                 1'b0, '0},
    '{OP_DELETE, 16'd2,      8'h00, 64'd0,                 1'b0, '0},
    '{OP_FIND,   16'd2,      8'h00, 64'd0,                 1'b0, '0},
    '{OP_DELETE, 16'd2,      8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_CLEAR,  16'hFFFF,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{STAT_OK, 6'd0, 16'd0}},
    '{OP_FIND,   16'd3,      8'h00, 64'd0,                 1'b1, '{STAT_NOT_FOUND, 6'd0, 16'd0}},
    '{OP_INSERT, 16'h1234,   8'h80, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{OP_INSERT, 16'h8000,   8'h7F, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
    '{OP_DELETE, 16'd4,      8'h00, 64'd0,                 1'b0, '0},
    '{OP_FIND,   16'd5,      8'h00, 64'd0,                 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            operation = OP_FIND;
  logic [KEY_W-1:0]      key = '0;
  logic [AGE_W-1:0]      age = '0;
  logic [NAME_W_MAX-1:0] name_payload = '0;
  logic                  done;
  logic [1:0]            status;
  logic [SLOT_W-1:0]     slot;
  logic [KEY_W-1:0]      assigned_key;

  // Typed-in expectation that travels with a directed command.
  logic                  row_fixed = 1'b0;
  response_t             row_expect = '0;

  // Mirror of the table contents used for prediction.
  logic [KEY_W-1:0]      mirror_keys [SLOTS];
  logic [AGE_W-1:0]      mirror_ages [SLOTS];
  logic [NAME_W_MAX-1:0] mirror_names [SLOTS];
  int                    mirror_count = 0;
  logic [KEY_W-1:0]      mirror_next_key = KEY_FIRST;

  response_t             pending_responses [$];
  int                    mismatches = 0;
  int                    results_checked = 0;
  int                    cmd_count [4] = '{0, 0, 0, 0};
  int                    full_seen = 0;
  int                    missing_seen = 0;
  int                    wraps_seen = 0;
  int                    idle_cycles = 0;
  bit                    bursty = 1'b1;
  int                    burst_left = 0;

  always #5 clk = ~clk;

  keyed_record_table_swap_remove u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .key          (key),
    .age          (age),
    .name_payload (name_payload),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .assigned_key (assigned_key)
  );

  function automatic response_t compute_table_response(
    input op_t                   op,
    input logic [KEY_W-1:0]      k,
    input logic [AGE_W-1:0]      a,
    input logic [NAME_W_MAX-1:0] nm
  );
    response_t r;
    int hit;
    int last;
    r = '{STAT_OK, '0, '0};
    hit = -1;
    for (int i = mirror_count - 1; i >= 0; i--) begin
      if (mirror_keys[i] == k) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (mirror_count >= SLOTS) begin
          r.status = STAT_FULL;
        end else begin
          mirror_keys[mirror_count] = mirror_next_key;
          mirror_ages[mirror_count] = a;
          mirror_names[mirror_count] = nm;
          r.slot = SLOT_W'(mirror_count);
          r.akey = mirror_next_key;
          mirror_count++;
          if (mirror_next_key == KEY_LAST) begin
            mirror_next_key = KEY_FIRST;
            wraps_seen++;
          end else begin
            mirror_next_key = mirror_next_key + 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          last = mirror_count - 1;
          mirror_keys[hit] = mirror_keys[last];
          mirror_ages[hit] = mirror_ages[last];
          mirror_names[hit] = mirror_names[last];
          mirror_count--;
          r.slot = SLOT_W'(hit);
        end
      end
      OP_FIND: begin
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else r.slot = SLOT_W'(hit);
      end
      default: begin
        mirror_count = 0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : response_monitor
    response_t want;
    response_t got;
    if (!rst) begin
      if (done) begin
        got = '{status_t'(status), slot, assigned_key};
        results_checked++;
        if (pending_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Unexpected result at %0t: status %0d slot %0d key %0d",
                     $realtime, got.status, got.slot, got.akey);
        end else begin
          want = pending_responses.pop_front();
          if (got.status != want.status || got.slot != want.slot ||
              got.akey != want.akey) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("Mismatch at %0t: expected status %0d slot %0d key %0d, %s %0d %0d %0d",
                       $realtime, want.status, want.slot, want.akey,
                       "got status/slot/key", got.status, got.slot, got.akey);
          end
        end
      end
      if (start && !busy) begin
        want = compute_table_response(op_t'(operation), key, age, name_payload);
        if (row_fixed) want = row_expect;
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_NOT_FOUND) missing_seen++;
        cmd_count[operation]++;
        pending_responses.push_back(want);
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(
    input op_t                   op,
    input logic [KEY_W-1:0]      k,
    input logic [AGE_W-1:0]      a,
    input logic [NAME_W_MAX-1:0] nm,
    input logic                  fixed,
    input response_t             fixed_resp
  );
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    start <= 1'b1;
    operation <= op;
    key <= k;
    age <= a;
    name_payload <= nm;
    row_fixed <= fixed;
    row_expect <= fixed_resp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [NAME_W_MAX-1:0] random_name;
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    response_t full_resp;
    logic [KEY_W-1:0] survivor;
    logic [KEY_W-1:0] k;
    mix_t mix;
    op_t op;
    int roll;
    full_resp = '{STAT_FULL, '0, '0};
    mix = MIX_BALANCED;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].age,
                   DIRECTED_ROWS[i].name, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].resp);

    // Fill the table to the last slot, then push against the full limit.
    send_command(OP_CLEAR, '0, '0, '0, 1'b1, '{STAT_OK, '0, '0});
    for (int i = 0; i < SLOTS; i++)
      send_command(OP_INSERT, 16'($urandom), 8'($urandom), random_name(), 1'b0, '0);
    send_command(OP_INSERT, '0, 8'hFF, '1, 1'b1, full_resp);
    send_command(OP_INSERT, '1, 8'h00, '0, 1'b1, full_resp);
    wait_drained();
    send_command(OP_FIND, mirror_keys[SLOTS-1], '0, '0, 1'b0, '0);
    send_command(OP_DELETE, mirror_keys[0], '0, '0, 1'b0, '0);
    send_command(OP_INSERT, '0, 8'h11, random_name(), 1'b0, '0);
    send_command(OP_INSERT, '0, 8'h22, random_name(), 1'b0, '0);

    // Remove the first record of a small table back to back and make sure
    // it stays gone.
    wait_drained();
    bursty = 1'b0;
    survivor = mirror_next_key;
    send_command(OP_CLEAR, '0, '0, '0, 1'b0, '0);
    send_command(OP_INSERT, '0, 8'h33, random_name(), 1'b0, '0);
    send_command(OP_INSERT, '0, 8'h44, random_name(), 1'b0, '0);
    send_command(OP_FIND, survivor, '0, '0, 1'b0, '0);
    send_command(OP_INSERT, '0, 8'h55, random_name(), 1'b0, '0);
    send_command(OP_DELETE, survivor, '0, '0, 1'b0, '0);
    send_command(OP_FIND, survivor, '0, '0, 1'b0, '0);
    send_command(OP_DELETE, survivor, '0, '0, 1'b0, '0);
    send_command(OP_FIND, survivor, '0, '0, 1'b0, '0);
    bursty = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 90 == 0) mix = mix_t'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:
          op = (roll < 75) ? OP_INSERT : (roll < 88) ? OP_FIND : OP_DELETE;
        MIX_DRAIN:
          op = (roll < 15) ? OP_INSERT : (roll < 40) ? OP_FIND :
               (roll < 98) ? OP_DELETE : OP_CLEAR;
        default:
          op = (roll < 40) ? OP_INSERT : (roll < 68) ? OP_FIND :
               (roll < 95) ? OP_DELETE : OP_CLEAR;
      endcase
      if (mirror_count > 0 && $urandom_range(0, 3) != 0)
        k = mirror_keys[$urandom_range(0, mirror_count - 1)];
      else
        k = 16'($urandom);
      send_command(op, k, 8'($urandom), random_name(), 1'b0, '0);
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Checked %0d results from %0d insert, %0d delete, %0d find, %0d clear commands.",
             results_checked, cmd_count[OP_INSERT], cmd_count[OP_DELETE],
             cmd_count[OP_FIND], cmd_count[OP_CLEAR]);
    $display("Saw %0d table-full and %0d key-not-found responses, %0d key counter wraps, %0d mismatches.",
             full_seen, missing_seen, wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/keyed_record_table_swap_remove.sv
test/tb_keyed_record_table_swap_remove.sv
